>>> rtl/pidr_pkg.sv
// Shared constants and types of the PID temperature regulator.
package pidr_pkg;

	localparam int unsigned CMD_W = 15;
	localparam logic [CMD_W-1:0] CMD_MAX   = 15'd25600;
	localparam logic [CMD_W-1:0] CMD_ONOFF = 15'd12800;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE       = 2'd0,
		REG_PROP_GAIN  = 2'd1,
		REG_INTEG_GAIN = 2'd2,
		REG_DERIV_GAIN = 2'd3
	} reg_idx_t;

	localparam logic        MODE_RST       = 1'b1;
	localparam logic [15:0] PROP_GAIN_RST  = 16'd4506;
	localparam logic [15:0] INTEG_GAIN_RST = 16'd8192;
	localparam logic [15:0] DERIV_GAIN_RST = 16'd61;

	localparam int unsigned FIFO_DEPTH = 2;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic        mode;
		logic [15:0] prop_gain;
		logic [15:0] integ_gain;
		logic [15:0] deriv_gain;
	} cfg_t;

	// classified sample handed from front to back
	typedef struct packed {
		logic        pid;
		logic        clear;
		logic        heat;
		logic [16:0] err;
		logic [16:0] prev;
	} job_t;

endpackage

>>> rtl/pidr_if.sv
// Valid/ready channels for samples and commands.
interface pidr_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] setpoint;
	logic signed [15:0] temperature;

	modport source(output valid, output setpoint, output temperature, input ready);
	modport sink(input valid, input setpoint, input temperature, output ready);
endinterface

interface pidr_out_if;
	logic        valid;
	logic        ready;
	logic [14:0] command;

	modport source(output valid, output command, input ready);
	modport sink(input valid, input command, output ready);
endinterface

>>> rtl/pidr_front.sv
// Front end: accepts samples, forms the error and tracks setpoint history.
module pidr_front
	import pidr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	pidr_in_if.sink samples,
	input  logic    mode,
	output logic    job_valid,
	output job_t    job,
	input  logic    job_ready
);

	logic               v_s1;
	job_t               job_s1;
	logic signed [16:0] last_err_q;
	logic signed [15:0] last_sp_q;
	logic               primed_q;
	logic               accept;
	logic signed [16:0] err;
	job_t               job_next;

	assign samples.ready = !v_s1 || job_ready;
	assign accept        = samples.valid && samples.ready;
	assign job_valid     = v_s1;
	assign job           = job_s1;

	always_comb begin
		err = {samples.setpoint[15], samples.setpoint}
			- {samples.temperature[15], samples.temperature};
		job_next.pid   = mode;
		job_next.clear = !primed_q || (samples.setpoint != last_sp_q);
		job_next.heat  = samples.temperature < samples.setpoint;
		job_next.err   = err;
		job_next.prev  = last_err_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			last_err_q <= '0;
			last_sp_q  <= '0;
			primed_q   <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (job_ready) begin
				v_s1 <= 1'b0;
			end
			// on/off samples leave the PID history alone
			if (accept && mode) begin
				last_err_q <= err;
				last_sp_q  <= samples.setpoint;
				primed_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job_next;
		end
	end

endmodule

>>> rtl/pidr_fifo.sv
// Short queue between front and back.
module pidr_fifo
	import pidr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  job_t push_data,
	output logic push_ready,
	output logic pop_valid,
	output job_t pop_data,
	input  logic pop_ready
);

	job_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               push;
	logic               pop;

	assign push_ready = count_q != FIFO_DEPTH[FIFO_AW:0];
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/pidr_back.sv
// Back end: gain products, integral update, command sum and clamp, or the on/off level.
module pidr_back
	import pidr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        job_valid,
	input  job_t        job,
	output logic        job_ready,
	pidr_out_if.source  commands
);

	logic en;

	// stage 2: products
	logic               v_s2;
	logic               pid_s2;
	logic               clear_s2;
	logic               heat_s2;
	logic signed [21:0] p_s2;
	logic signed [20:0] inc_s2;
	logic signed [21:0] d_s2;

	// stage 3: integral and P+D
	logic               v_s3;
	logic               pid_s3;
	logic               heat_s3;
	logic signed [22:0] pd_s3;
	logic signed [31:0] isum_s3;

	logic signed [31:0] integ_q;
	logic               out_v_q;
	logic [CMD_W-1:0]   cmd_q;

	logic signed [17:0] sum_e;
	logic signed [17:0] diff_e;
	logic signed [33:0] prod_p;
	logic signed [33:0] prod_i;
	logic signed [33:0] prod_d;
	logic signed [21:0] d_eff;
	logic signed [22:0] pd;
	logic signed [32:0] isum_wide;
	logic signed [31:0] isum;
	logic signed [33:0] total;
	logic [CMD_W-1:0]   cmd_next;

	assign en        = !out_v_q || commands.ready;
	assign job_ready = en;
	assign commands.valid   = out_v_q;
	assign commands.command = cmd_q;

	always_comb begin
		sum_e  = $signed({job.prev[16], job.prev}) + $signed({job.err[16], job.err});
		diff_e = $signed({job.err[16], job.err}) - $signed({job.prev[16], job.prev});
		prod_p = $signed({1'b0, cfg.prop_gain}) * $signed(job.err);
		prod_i = $signed({1'b0, cfg.integ_gain}) * sum_e;
		prod_d = $signed({1'b0, cfg.deriv_gain}) * diff_e;
	end

	always_comb begin
		d_eff = clear_s2 ? '0 : d_s2;
		pd    = $signed({p_s2[21], p_s2}) + $signed({d_eff[21], d_eff});
		isum_wide = $signed({integ_q[31], integ_q}) + $signed({{12{inc_s2[20]}}, inc_s2});
		if (clear_s2) begin
			isum = '0;
		end else if (isum_wide[32] != isum_wide[31]) begin
			isum = isum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			isum = isum_wide[31:0];
		end
	end

	always_comb begin
		total = $signed({{2{isum_s3[31]}}, isum_s3}) + $signed({{11{pd_s3[22]}}, pd_s3});
		if (!pid_s3) begin
			cmd_next = heat_s3 ? CMD_ONOFF : '0;
		end else if (total[33]) begin
			cmd_next = '0;
		end else if (total > $signed({19'd0, CMD_MAX})) begin
			cmd_next = CMD_MAX;
		end else begin
			cmd_next = total[CMD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
			integ_q <= '0;
		end else if (en) begin
			v_s2    <= job_valid;
			v_s3    <= v_s2;
			out_v_q <= v_s3;
			if (v_s2 && pid_s2) begin
				integ_q <= isum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pid_s2   <= job.pid;
			clear_s2 <= job.clear;
			heat_s2  <= job.heat;
			p_s2     <= prod_p[33:12];
			inc_s2   <= prod_i[33:13];
			d_s2     <= prod_d[33:12];
			pid_s3   <= pid_s2;
			heat_s3  <= heat_s2;
			pd_s3    <= pd;
			isum_s3  <= isum;
			cmd_q    <= cmd_next;
		end
	end

endmodule

>>> rtl/pid_temperature_regulator_unit.sv
// PID temperature regulator, top level.
//
// samples: setpoint and temperature (signed Q8.8) per item, valid/ready.
// commands: heater drive in percent, Q8.8 0..25600, one item per sample.
// cfg_wr_en/cfg_index/cfg_data write mode and the three Q4.12 gains; write
// only while no sample is in flight.
// A sample passes the front stage register, the queue, back stages 2 and 3
// and the output register. Throughput: one sample per cycle while nothing
// stalls, set by the integral add/saturate loop in the back end.
// A two-entry queue sits between the front (error, setpoint history) and the
// back (gain products, integral, clamp). When commands.ready is low the back
// holds its output item and stops; the front keeps taking samples until the
// queue and its own stage are full, then drops samples.ready.
// Reset loads the default gains and PID mode, clears the integral and the
// history; the first PID sample after reset starts with a cleared integral.
module pid_temperature_regulator_unit
	import pidr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	pidr_in_if.sink               samples,
	pidr_out_if.source            commands,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	logic front_valid;
	job_t front_job;
	logic front_ready;
	logic back_valid;
	job_t back_job;
	logic back_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= MODE_RST;
			cfg_q.prop_gain  <= PROP_GAIN_RST;
			cfg_q.integ_gain <= INTEG_GAIN_RST;
			cfg_q.deriv_gain <= DERIV_GAIN_RST;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_MODE:       cfg_q.mode       <= cfg_data[0];
				REG_PROP_GAIN:  cfg_q.prop_gain  <= cfg_data;
				REG_INTEG_GAIN: cfg_q.integ_gain <= cfg_data;
				REG_DERIV_GAIN: cfg_q.deriv_gain <= cfg_data;
				default: ;
			endcase
		end
	end

	pidr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.mode      (cfg_q.mode),
		.job_valid (front_valid),
		.job       (front_job),
		.job_ready (front_ready)
	);

	pidr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_data  (front_job),
		.push_ready (front_ready),
		.pop_valid  (back_valid),
		.pop_data   (back_job),
		.pop_ready  (back_ready)
	);

	pidr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (back_valid),
		.job       (back_job),
		.job_ready (back_ready),
		.commands  (commands)
	);

endmodule

>>> rtl/pidr_checker.sv
// Port-level checks of the regulator, bound to the top level.
module pidr_checker
	import pidr_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [14:0]           command,
	input logic                  cfg_wr_en,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	logic mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RST;
		end else if (cfg_wr_en && (cfg_index == REG_MODE)) begin
			mode_q <= cfg_data[0];
		end
	end

	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> command <= CMD_MAX)
		else $error("command above full scale");

	a_onoff_levels: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !mode_q) |-> (command == CMD_ONOFF || command == '0))
		else $error("on/off command not 0 or half scale");

	// while reset is held, the output stage has been cleared
	a_reset_empty: assert property (@(posedge clk)
		(!arst_n && $past(!arst_n)) |-> !out_valid)
		else $error("result shown during reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(command)))
		else $error("stalled result changed");

endmodule

bind pid_temperature_regulator_unit pidr_checker u_pidr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (commands.valid),
	.out_ready (commands.ready),
	.command   (commands.command),
	.cfg_wr_en (cfg_wr_en),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);
